// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the machine's RTL files.
// Each macro names the check, the clock, the active-low reset, a condition and
// what must hold when the condition is true.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define BSM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsm assertion failed");

// The consequence must hold in the cycle after the condition.
`define BSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsm assertion failed");

`endif

// ===== rtl/core/bsm_pkg.sv =====
package bsm_pkg;

    // Byte-wide data path and fixed field widths.
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int KIND_W   = 2;

    // Store sizes; both may range from 16 to 256 entries.
    localparam int PROGRAM_DEPTH = 256;
    localparam int STACK_DEPTH   = 256;
    localparam int PROG_AW       = $clog2(PROGRAM_DEPTH);
    localparam int STACK_AW      = $clog2(STACK_DEPTH);

    // A byte address widened by one bit, so that store limits compare cleanly.
    typedef logic [BYTE_W:0] addr_ext_t;
    localparam addr_ext_t PROG_LIMIT = addr_ext_t'(PROGRAM_DEPTH);

    // A push is refused once the depth reaches this level.
    localparam logic [BYTE_W-1:0] STACK_FULL_LEVEL = BYTE_W'(STACK_DEPTH - 1);

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXEC  = 2'd2;

    // Run status codes.
    localparam logic [STATUS_W-1:0] ST_RUNNING  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HALTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PC_RANGE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd5;

    // Opcodes.
    localparam logic [BYTE_W-1:0] OP_HALT  = 8'h00;
    localparam logic [BYTE_W-1:0] OP_PRINT = 8'h01;
    localparam logic [BYTE_W-1:0] OP_PUSH  = 8'h02;
    localparam logic [BYTE_W-1:0] OP_ADD   = 8'h03;
    localparam logic [BYTE_W-1:0] OP_POPPR = 8'h04;
    localparam logic [BYTE_W-1:0] OP_JUMP  = 8'h05;
    localparam logic [BYTE_W-1:0] OP_JZ    = 8'h06;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // input beat taken this cycle
        logic fetch;     // opcode and top of stack on the read ports
        logic execute;   // immediate and second entry on the read ports
        logic out_load;  // capture the result into the output register
    } bsm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic exec_go;   // the offered beat starts an instruction fetch
    } bsm_stat_t;

endpackage

// ===== rtl/core/bsm_ram.sv =====
module bsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bsm_datapath.sv =====
`include "assert_macros.svh"

module bsm_datapath import bsm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  bsm_cmd_t            cmd,
    output bsm_stat_t           stat,
    input  logic [KIND_W-1:0]   s_tuser,
    input  logic [15:0]         s_tdata,
    input  logic                cfg_wr_en,
    input  logic [BYTE_W-1:0]   cfg_wr_data,
    output logic [31:0]         m_tdata,
    output logic [0:0]          m_tuser
);

    logic [BYTE_W-1:0]   len_reg;
    logic [BYTE_W-1:0]   pc_reg, pc_next;
    logic [BYTE_W-1:0]   depth_reg, depth_next;
    logic [STATUS_W-1:0] run_reg, run_next;
    logic                char_valid_reg, char_valid_next;
    logic [BYTE_W-1:0]   char_reg, char_next;
    logic [BYTE_W-1:0]   op_reg, op_next;
    logic [BYTE_W-1:0]   top_reg, top_next;

    logic [BYTE_W-1:0]   out_char_reg;
    logic                out_char_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BYTE_W-1:0]   out_pc_reg;
    logic [BYTE_W-1:0]   out_depth_reg;

    logic [PROGRAM_DEPTH-1:0] prog_valid_reg;
    logic                     prog_rd_ok_reg;

    logic [KIND_W-1:0] in_kind;
    logic [BYTE_W-1:0] in_addr;
    logic [BYTE_W-1:0] in_byte;
    logic              in_addr_ok;
    logic              prog_we;

    logic [BYTE_W-1:0] prog_raddr;
    logic              prog_raddr_ok;
    logic [BYTE_W-1:0] prog_q;
    logic [BYTE_W-1:0] prog_byte;

    logic [BYTE_W-1:0] stack_raddr;
    logic [BYTE_W-1:0] stack_q;
    logic              stack_we;
    logic [BYTE_W-1:0] stack_waddr;
    logic [BYTE_W-1:0] stack_wdata;

    logic [BYTE_W-1:0] pc_plus1;
    logic [BYTE_W-1:0] pc_plus2;
    logic              imm_ok;
    logic              target_ok;
    logic              stack_full;

    assign in_kind = s_tuser;
    assign in_addr = s_tdata[7:0];
    assign in_byte = s_tdata[15:8];

    assign in_addr_ok = {1'b0, in_addr} < PROG_LIMIT;
    assign prog_we    = cmd.accept && (in_kind == KIND_WRITE) && in_addr_ok;

    assign stat.exec_go = (in_kind == KIND_EXEC) && (run_reg == ST_RUNNING)
                          && (pc_reg < len_reg);

    // Reads: opcode at pc first, the immediate at pc + 1 (wrapping) next.
    assign pc_plus1      = pc_reg + 8'd1;
    assign pc_plus2      = pc_reg + 8'd2;
    assign prog_raddr    = cmd.fetch ? pc_plus1 : pc_reg;
    assign prog_raddr_ok = {1'b0, prog_raddr} < PROG_LIMIT;
    assign stack_raddr   = cmd.fetch ? (depth_reg - 8'd1) : depth_reg;

    // Bytes never written, or beyond the store, read as zero.
    assign prog_byte = prog_rd_ok_reg ? prog_q : '0;

    assign imm_ok     = ({1'b0, pc_reg} + addr_ext_t'(1)) < {1'b0, len_reg};
    assign target_ok  = prog_byte < len_reg;
    assign stack_full = depth_reg >= STACK_FULL_LEVEL;

    bsm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PROGRAM_DEPTH)
    ) u_prog_ram (
        .aclk    (aclk),
        .wr_en   (prog_we),
        .wr_addr (in_addr[PROG_AW-1:0]),
        .wr_data (in_byte),
        .rd_addr (prog_raddr[PROG_AW-1:0]),
        .rd_data (prog_q)
    );

    bsm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stack_we),
        .wr_addr (stack_waddr[STACK_AW-1:0]),
        .wr_data (stack_wdata),
        .rd_addr (stack_raddr[STACK_AW-1:0]),
        .rd_data (stack_q)
    );

    always_comb begin
        pc_next         = pc_reg;
        depth_next      = depth_reg;
        run_next        = run_reg;
        char_valid_next = char_valid_reg;
        char_next       = char_reg;
        op_next         = op_reg;
        top_next        = top_reg;
        stack_we        = 1'b0;
        stack_waddr     = depth_reg;
        stack_wdata     = prog_byte;

        if (cmd.accept) begin
            char_valid_next = 1'b0;
            char_next       = '0;
            case (in_kind)
                KIND_START: begin
                    pc_next    = '0;
                    depth_next = '0;
                    run_next   = ST_RUNNING;
                end
                KIND_EXEC: begin
                    if ((run_reg == ST_RUNNING) && (pc_reg >= len_reg)) begin
                        run_next = ST_HALTED;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cmd.fetch) begin
            op_next  = prog_byte;
            top_next = stack_q;
        end

        if (cmd.execute) begin
            case (op_reg)
                OP_HALT: begin
                    run_next = ST_HALTED;
                end
                OP_PRINT: begin
                    if (!imm_ok) begin
                        run_next = ST_PC_RANGE;
                    end else begin
                        char_valid_next = 1'b1;
                        char_next       = prog_byte;
                        pc_next         = pc_plus2;
                    end
                end
                OP_PUSH: begin
                    if (!imm_ok) begin
                        run_next = ST_PC_RANGE;
                    end else if (stack_full) begin
                        run_next = ST_FULL;
                    end else begin
                        depth_next  = depth_reg + 8'd1;
                        stack_we    = 1'b1;
                        stack_waddr = depth_reg + 8'd1;
                        stack_wdata = prog_byte;
                        pc_next     = pc_plus2;
                    end
                end
                OP_ADD: begin
                    // With a single entry the first pop still takes effect.
                    if (depth_reg == 8'd0) begin
                        run_next = ST_EMPTY;
                    end else if (depth_reg == 8'd1) begin
                        depth_next = '0;
                        run_next   = ST_EMPTY;
                    end else begin
                        depth_next  = depth_reg - 8'd1;
                        stack_we    = 1'b1;
                        stack_waddr = depth_reg - 8'd1;
                        stack_wdata = top_reg + stack_q;
                        pc_next     = pc_plus1;
                    end
                end
                OP_POPPR: begin
                    if (depth_reg == 8'd0) begin
                        run_next = ST_EMPTY;
                    end else begin
                        char_valid_next = 1'b1;
                        char_next       = top_reg;
                        depth_next      = depth_reg - 8'd1;
                        pc_next         = pc_plus1;
                    end
                end
                OP_JUMP: begin
                    // The target byte is read without checking it lies in the program.
                    if (!target_ok) begin
                        run_next = ST_PC_RANGE;
                    end else begin
                        pc_next = prog_byte;
                    end
                end
                OP_JZ: begin
                    if (depth_reg == 8'd0) begin
                        run_next = ST_EMPTY;
                    end else if (!imm_ok) begin
                        run_next = ST_PC_RANGE;
                    end else if (top_reg == 8'd0) begin
                        if (!target_ok) begin
                            run_next = ST_PC_RANGE;
                        end else begin
                            pc_next = prog_byte;
                        end
                    end else begin
                        pc_next = pc_plus2;
                    end
                end
                default: begin
                    run_next = ST_UNKNOWN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= '0;
            pc_reg         <= '0;
            depth_reg      <= '0;
            run_reg        <= ST_HALTED;
            char_valid_reg <= 1'b0;
            prog_valid_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
            end
            pc_reg         <= pc_next;
            depth_reg      <= depth_next;
            run_reg        <= run_next;
            char_valid_reg <= char_valid_next;
            if (prog_we) begin
                prog_valid_reg[in_addr[PROG_AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        char_reg       <= char_next;
        op_reg         <= op_next;
        top_reg        <= top_next;
        prog_rd_ok_reg <= prog_raddr_ok && prog_valid_reg[prog_raddr[PROG_AW-1:0]];
        if (cmd.out_load) begin
            out_char_valid_reg <= char_valid_reg;
            out_char_reg       <= char_reg;
            out_status_reg     <= run_reg;
            out_pc_reg         <= pc_reg;
            out_depth_reg      <= depth_reg;
        end
    end

    assign m_tdata = {5'd0, out_depth_reg, out_pc_reg, out_status_reg, out_char_reg};
    assign m_tuser = out_char_valid_reg;

    `BSM_ASSERT_SAME(a_depth_bounded, aclk, aresetn, 1'b1, depth_reg <= STACK_FULL_LEVEL)
    `BSM_ASSERT_SAME(a_char_only_running, aclk, aresetn, char_valid_reg, run_reg == ST_RUNNING)
    `BSM_ASSERT_NEXT(a_stopped_holds_pc, aclk, aresetn,
                     cmd.execute && (run_reg != ST_RUNNING), pc_reg == $past(pc_reg))

endmodule

// ===== rtl/core/bsm_ctrl.sv =====
`include "assert_macros.svh"

module bsm_ctrl import bsm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  bsm_stat_t stat,
    output bsm_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_OPER  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.accept   = s_tvalid && s_tready;
        cmd.fetch    = (state_reg == S_FETCH);
        cmd.execute  = (state_reg == S_OPER);
        cmd.out_load = (state_reg == S_DONE) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept) begin
                    state_next = stat.exec_go ? S_FETCH : S_DONE;
                end
            end
            S_FETCH: begin
                state_next = S_OPER;
            end
            S_OPER: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `BSM_ASSERT_SAME(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_tvalid_reg || m_tready)
    `BSM_ASSERT_SAME(a_oper_after_fetch, aclk, aresetn,
                     state_reg == S_OPER, $past(state_reg) == S_FETCH)

endmodule

// ===== rtl/core/byte_stack_machine_step.sv =====
// Byte stack machine, one instruction per execute beat. Each input beat on the
// s_ side either writes a program byte, starts the program (pc and stack depth
// cleared, status running), executes the instruction at pc or, for kind three,
// does nothing, and every input beat gives exactly one result beat on the m_
// side carrying the printed character, if any, together with the status, pc
// and stack depth left behind. An execute beat that finds the machine running
// and pc inside the program passes through the fetch, operate and done states.
// The opcode and top of stack are read at the accepting edge. The next cycle
// captures them and reads the immediate and the second stack entry, the cycle
// after that executes and writes back, and the done state then loads the
// output register once it is free. No new beat is accepted until these steps
// are through; they are set by the single read port of each store. All other
// beats go from acceptance straight to the done state. A result may wait in
// the output register while the next beat is accepted; that next beat then
// completes only once the result is taken. The program length register is to
// be written through cfg_wr_en and cfg_wr_data only while the machine is idle;
// the block itself does not enforce this. After reset the program store reads
// as all zero, the length is zero and the status is halted until a start beat
// arrives.
module byte_stack_machine_step import bsm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,

    // Program length register.
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,

    // Input beats.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // load_address [7:0], load_byte [15:8]
    input  logic [KIND_W-1:0] s_tuser,   // kind [1:0]

    // Result beats.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // char_out [7:0], status [10:8],
                                         // program_counter [18:11],
                                         // stack_depth [26:19], zero [31:27]
    output logic [0:0]        m_tuser    // char_valid [0]
);

    // The controller sequences the beat; the datapath holds all machine state.
    bsm_cmd_t  cmd;
    bsm_stat_t stat;

    bsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== bench/tb_byte_stack_machine_step.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the byte stack machine. Every input beat is mirrored
// in a behavioural copy of the machine at the moment it is accepted. The copy
// produces the result that the beat must give, and every result beat is
// compared field by field against the oldest such prediction.
module tb_byte_stack_machine_step;
    import bsm_pkg::*;

    // Kind three is not named in the package. The machine only reports its
    // state for it.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // Cycles without any handshake before the run is declared hung. The
    // longest deliberate stall is the receiver hold-off that HOLD_CYCLES sets.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    // The directed tests, the stack overflow above all, already send some six
    // hundred beats; the random phases share the rest of about eight hundred.
    localparam int RANDOM_ITEMS   = 150;

    typedef struct packed {
        logic                char_valid;
        logic [BYTE_W-1:0]   char_out;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   pc;
        logic [BYTE_W-1:0]   depth;
    } step_result_t;

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [BYTE_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata     = '0;   // load_address [7:0], load_byte [15:8]
    logic [KIND_W-1:0]   s_tuser     = '0;   // kind [1:0]
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [31:0]         m_tdata;            // char_out [7:0], status [10:8],
                                             // program_counter [18:11],
                                             // stack_depth [26:19], zero [31:27]
    logic [0:0]          m_tuser;            // char_valid [0]

    byte_stack_machine_step DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // The bench's own copy of the machine state.
    logic [BYTE_W-1:0]   prog_mem  [PROGRAM_DEPTH];
    logic [BYTE_W-1:0]   stack_mem [STACK_DEPTH];
    logic [BYTE_W-1:0]   mdl_pc;
    logic [BYTE_W-1:0]   mdl_depth;
    logic [BYTE_W-1:0]   mdl_length;
    logic [STATUS_W-1:0] mdl_status;

    step_result_t        expected_steps [$];
    logic [BYTE_W-1:0]   program_image  [$];

    int error_count   = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Behavioural copy of the machine.
    // ------------------------------------------------------------------

    function automatic void model_reset();
        foreach (prog_mem[i]) prog_mem[i] = '0;
        foreach (stack_mem[i]) stack_mem[i] = '0;
        mdl_pc     = '0;
        mdl_depth  = '0;
        mdl_length = '0;
        mdl_status = ST_HALTED;
    endfunction

    // Reads past the end of the program store give zero.
    function automatic logic [BYTE_W-1:0] fetch_byte(int unsigned addr);
        if (addr < PROGRAM_DEPTH) return prog_mem[addr];
        return '0;
    endfunction

    // Runs the instruction at pc. Returns 1 when a character was printed.
    // A failing instruction leaves pc where it was, but an add that fails on
    // a short stack keeps the pops that it has already made.
    function automatic logic execute_instruction(output logic [BYTE_W-1:0] ch);
        int unsigned       len;
        int unsigned       pc;
        int unsigned       target;
        logic [BYTE_W-1:0] op;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        len = mdl_length;
        pc  = mdl_pc;
        ch  = '0;
        if (pc >= len) begin
            mdl_status = ST_HALTED;
            return 1'b0;
        end
        op = fetch_byte(pc);
        case (op)
            OP_HALT: begin
                mdl_status = ST_HALTED;
            end
            OP_PRINT: begin
                if (pc + 1 >= len) begin
                    mdl_status = ST_PC_RANGE;
                end else begin
                    ch     = fetch_byte(pc + 1);
                    mdl_pc = BYTE_W'(pc + 2);
                    return 1'b1;
                end
            end
            OP_PUSH: begin
                if (pc + 1 >= len) begin
                    mdl_status = ST_PC_RANGE;
                end else if (int'(mdl_depth) >= STACK_DEPTH - 1) begin
                    mdl_status = ST_FULL;
                end else begin
                    mdl_depth            = mdl_depth + 1'b1;
                    stack_mem[mdl_depth] = fetch_byte(pc + 1);
                    mdl_pc               = BYTE_W'(pc + 2);
                end
            end
            OP_ADD: begin
                if (mdl_depth == 0) begin
                    mdl_status = ST_EMPTY;
                end else begin
                    a         = stack_mem[mdl_depth];
                    mdl_depth = mdl_depth - 1'b1;
                    if (mdl_depth == 0) begin
                        mdl_status = ST_EMPTY;
                    end else begin
                        b         = stack_mem[mdl_depth];
                        mdl_depth = mdl_depth - 1'b1;
                        if (int'(mdl_depth) >= STACK_DEPTH - 1) begin
                            mdl_status = ST_FULL;
                        end else begin
                            mdl_depth            = mdl_depth + 1'b1;
                            stack_mem[mdl_depth] = a + b;
                            mdl_pc               = BYTE_W'(pc + 1);
                        end
                    end
                end
            end
            OP_POPPR: begin
                if (mdl_depth == 0) begin
                    mdl_status = ST_EMPTY;
                end else begin
                    ch        = stack_mem[mdl_depth];
                    mdl_depth = mdl_depth - 1'b1;
                    mdl_pc    = BYTE_W'(pc + 1);
                    return 1'b1;
                end
            end
            OP_JUMP: begin
                // The target byte is read even when it lies past the length.
                target = fetch_byte(BYTE_W'(pc + 1));
                if (target >= len) mdl_status = ST_PC_RANGE;
                else mdl_pc = BYTE_W'(target);
            end
            OP_JZ: begin
                if (mdl_depth == 0) begin
                    mdl_status = ST_EMPTY;
                end else if (pc + 1 >= len) begin
                    mdl_status = ST_PC_RANGE;
                end else if (stack_mem[mdl_depth] == 0) begin
                    target = fetch_byte(pc + 1);
                    if (target >= len) mdl_status = ST_PC_RANGE;
                    else mdl_pc = BYTE_W'(target);
                end else begin
                    mdl_pc = BYTE_W'(pc + 2);
                end
            end
            default: begin
                mdl_status = ST_UNKNOWN;
            end
        endcase
        return 1'b0;
    endfunction

    // Applies one accepted beat to the copy and returns the result it gives.
    function automatic step_result_t predict_step(logic [KIND_W-1:0] kind,
                                                  logic [BYTE_W-1:0] addr,
                                                  logic [BYTE_W-1:0] data);
        step_result_t      r;
        logic [BYTE_W-1:0] ch;
        logic              printed;
        printed = 1'b0;
        ch      = '0;
        case (kind)
            KIND_WRITE: begin
                if (int'(addr) < PROGRAM_DEPTH) prog_mem[addr] = data;
            end
            KIND_START: begin
                mdl_pc     = '0;
                mdl_depth  = '0;
                mdl_status = ST_RUNNING;
            end
            KIND_EXEC: begin
                // A machine that is not running stays frozen.
                if (mdl_status == ST_RUNNING) printed = execute_instruction(ch);
            end
            default: begin
            end
        endcase
        r.char_valid = printed;
        r.char_out   = printed ? ch : '0;
        r.status     = mdl_status;
        r.pc         = mdl_pc;
        r.depth      = mdl_depth;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving the input side.
    // ------------------------------------------------------------------

    // Offers one beat and returns at the edge at which it is taken. The valid
    // stays high afterwards, so that back-to-back beats need no gap; a gap,
    // when one is drawn, lowers it at the start of the next call.
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [BYTE_W-1:0] addr,
                             input logic [BYTE_W-1:0] data);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {data, addr};
        do @(posedge aclk); while (!s_tready);
        expected_steps.push_back(predict_step(kind, addr, data));
        if (kind != KIND_NONE) items_sent++;
    endtask

    // Stops offering beats and waits until every predicted result has come
    // back, plus a short margin so that the machine is quite idle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // The length register is only ever written while the machine is idle.
    task automatic write_length(input logic [BYTE_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        mdl_length = value;
        @(posedge aclk);
    endtask

    // Writes program_image into the store from address zero upwards.
    task automatic load_program();
        foreach (program_image[i]) send_item(KIND_WRITE, BYTE_W'(i), program_image[i]);
    endtask

    // Starts the program and steps it until it stops or the step budget runs
    // out, then sends one more execute beat, which a stopped machine must
    // answer by repeating its status.
    task automatic run_program(input int max_steps);
        int steps;
        steps = 0;
        send_item(KIND_START, BYTE_W'($urandom), BYTE_W'($urandom));
        while (mdl_status == ST_RUNNING && steps < max_steps) begin
            send_item(KIND_EXEC, BYTE_W'($urandom), BYTE_W'($urandom));
            steps++;
        end
        send_item(KIND_EXEC, BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Straight after reset the machine is halted with an empty program.
    task automatic test_after_reset();
        send_item(KIND_EXEC, 8'h00, 8'h00);
        send_item(KIND_NONE, 8'hFF, 8'hFF);
        send_item(KIND_WRITE, 8'hFF, 8'hFF);
        send_item(KIND_WRITE, 8'h00, 8'h00);
        send_item(KIND_NONE, 8'h00, 8'h00);
        // With a length of zero the first execute halts at once.
        write_length(8'd0);
        run_program(4);
    endtask

    // One program that uses every opcode, including an add that wraps,
    // a printed zero, a taken and an untaken conditional jump, and a halt.
    task automatic test_each_opcode();
        program_image = {
            OP_PRINT, 8'h48,         // 0
            OP_PUSH,  8'hC8,         // 2
            OP_PUSH,  8'h64,         // 4
            OP_ADD,                  // 6: 200 + 100 wraps to 44
            OP_POPPR,                // 7
            OP_PUSH,  8'h00,         // 8
            OP_JZ,    8'h0D,         // 10: taken, the top stays
            8'h07,                   // 12: skipped
            OP_POPPR,                // 13: prints zero
            OP_PUSH,  8'hFF,         // 14
            OP_JZ,    8'h00,         // 16: not taken
            OP_JUMP,  8'h15,         // 18
            8'h07,                   // 20: skipped
            OP_POPPR,                // 21
            OP_HALT                  // 22
        };
        load_program();
        write_length(8'd23);
        run_program(30);
    endtask

    // The same program cut short before its halt: pc reaches the length.
    task automatic test_run_off_end();
        write_length(8'd22);
        run_program(30);
    endtask

    // Add, pop and conditional jump on a stack that is too short.
    task automatic test_short_stack();
        program_image = {OP_PUSH, 8'h07, OP_ADD};
        load_program();
        write_length(8'd3);
        run_program(8);
        program_image = {OP_ADD};
        load_program();
        write_length(8'd1);
        run_program(4);
        program_image = {OP_POPPR};
        load_program();
        run_program(4);
        program_image = {OP_JZ};
        load_program();
        run_program(4);
    endtask

    // Opcodes whose immediate would lie past the length.
    task automatic test_missing_immediate();
        program_image = {OP_PRINT};
        load_program();
        write_length(8'd1);
        run_program(4);
        program_image = {OP_PUSH};
        load_program();
        run_program(4);
        program_image = {OP_PUSH, 8'h00, OP_JZ};
        load_program();
        write_length(8'd3);
        run_program(6);
    endtask

    // Jump targets outside the program, and an unconditional jump whose
    // immediate lies past the length but whose target is valid.
    task automatic test_jump_targets();
        program_image = {OP_JUMP, 8'h04, OP_HALT, OP_HALT};
        load_program();
        write_length(8'd4);
        run_program(4);
        program_image = {OP_PUSH, 8'h00, OP_JZ, 8'h09};
        load_program();
        run_program(6);
        program_image = {OP_JUMP, 8'h00};
        load_program();
        write_length(8'd1);
        run_program(3);
    endtask

    task automatic test_unknown_opcode();
        program_image = {8'h07};
        load_program();
        write_length(8'd1);
        run_program(4);
        program_image = {8'hFF};
        load_program();
        run_program(4);
    endtask

    // A push loop fills the stack until a push is refused. The receiver holds
    // off for a long stretch at the start, so that the machine backs up and
    // stalls its input while beats are still on offer.
    task automatic test_stack_overflow();
        program_image = {OP_PUSH, BYTE_W'($urandom), OP_JUMP, 8'h00};
        load_program();
        write_length(8'd4);
        hold_request = HOLD_CYCLES;
        run_program(600);
        // Pause until every result is back, then check that a start empties
        // the stack again.
        drain_results();
        run_program(3);
    endtask

    // A random program of mostly valid instructions, now and then an unknown
    // opcode, with random immediates; jump targets mostly land inside it.
    task automatic random_program();
        int                n;
        int                pick;
        logic [BYTE_W-1:0] len_value;
        n = $urandom_range(2, 16);
        program_image = {};
        while (program_image.size() < n) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                program_image.push_back(OP_PUSH);
                program_image.push_back(($urandom_range(3) == 0) ? 8'h00
                                                                : BYTE_W'($urandom));
            end else if (pick < 42) begin
                program_image.push_back(OP_PRINT);
                program_image.push_back(BYTE_W'($urandom));
            end else if (pick < 54) begin
                program_image.push_back(OP_ADD);
            end else if (pick < 66) begin
                program_image.push_back(OP_POPPR);
            end else if (pick < 88) begin
                program_image.push_back((pick < 76) ? OP_JUMP : OP_JZ);
                program_image.push_back(($urandom_range(7) == 0) ? BYTE_W'($urandom)
                                        : BYTE_W'($urandom_range(0, n - 1)));
            end else if (pick < 93) begin
                program_image.push_back(OP_HALT);
            end else begin
                program_image.push_back(BYTE_W'($urandom_range(7, 255)));
            end
        end
        load_program();
        pick      = $urandom_range(19);
        len_value = BYTE_W'(program_image.size());
        // Now and then the extremes of the length, or a length that cuts off
        // the final byte.
        if (pick == 0) len_value = 8'd0;
        else if (pick == 1) len_value = 8'd255;
        else if (pick == 2) len_value = len_value - 1'b1;
        write_length(len_value);
        run_program(40);
    endtask

    // Beats of any kind with random fields.
    task automatic random_noise();
        repeat ($urandom_range(4, 12)) begin
            send_item(KIND_W'($urandom_range(3)), BYTE_W'($urandom), BYTE_W'($urandom));
        end
    endtask

    task automatic test_random(input int quota);
        int target;
        target = items_sent + quota;
        while (items_sent < target) begin
            if ($urandom_range(99) < 80) random_program();
            else random_noise();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, result checking and watchdog.
    // ------------------------------------------------------------------

    // The receiver takes results at random, or holds off entirely for the
    // number of cycles that a test asks for.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        step_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_steps.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h/%h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                want = expected_steps.pop_front();
                check_field("char_valid", want.char_valid, m_tuser[0]);
                check_field("char_out", want.char_out, m_tdata[7:0]);
                check_field("status", want.status, m_tdata[10:8]);
                check_field("program_counter", want.pc, m_tdata[18:11]);
                check_field("stack_depth", want.depth, m_tdata[26:19]);
                check_field("padding", 0, m_tdata[31:27]);
            end
        end
    end

    // Ends the run if neither side completes a beat for too long.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of tests.
    // ------------------------------------------------------------------

    initial begin
        model_reset();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles rarely, receiver often.
        send_idle_pct = 13;
        recv_idle_pct = 84;
        test_after_reset();
        test_each_opcode();
        test_run_off_end();
        test_short_stack();
        test_missing_immediate();
        test_jump_targets();
        test_unknown_opcode();
        test_stack_overflow();
        test_random(RANDOM_ITEMS / 3);

        // The other way round.
        send_idle_pct = 84;
        recv_idle_pct = 13;
        test_random(RANDOM_ITEMS / 3);

        // Neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(RANDOM_ITEMS / 3);

        drain_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0 && expected_steps.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
